// ----- sv/qrm_pkg.sv -----
package qrm_pkg;

    typedef struct packed {
        logic signed [15:0] quat_i;
        logic signed [15:0] quat_j;
        logic signed [15:0] quat_k;
        logic signed [15:0] quat_r;
    } quat_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
        logic               zero_quat;
    } mat_t;

    localparam int unsigned NUM_ENTRIES = 9;
    localparam int unsigned NORM_W      = 33;
    localparam int unsigned REM_W       = 34;
    localparam int unsigned NUM_W       = 35;

    typedef struct packed {
        logic [30:0]        ii;
        logic [30:0]        jj;
        logic [30:0]        kk;
        logic [30:0]        rr;
        logic signed [31:0] ij;
        logic signed [31:0] ik;
        logic signed [31:0] jk;
        logic signed [31:0] ir;
        logic signed [31:0] jr;
        logic signed [31:0] kr;
    } prod_t;

    typedef struct packed {
        logic [NORM_W-1:0]                        norm;
        logic [NUM_ENTRIES-1:0][NUM_W-1:0]        num;
    } numer_t;

    typedef struct packed {
        logic                   valid;
        logic                   zero;
        logic [NUM_ENTRIES-1:0] neg;
        logic [NORM_W-1:0]      norm;
    } dctl_t;

endpackage

// ----- sv/qrm_if.sv -----
interface qrm_quat_if;
    logic            valid;
    logic            ready;
    qrm_pkg::quat_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface qrm_mat_if;
    logic            valid;
    logic            ready;
    qrm_pkg::mat_t   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/qrm_mul.sv -----
module qrm_mul (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           valid,
    input  qrm_pkg::quat_t quat,
    output logic           prod_valid,
    output qrm_pkg::prod_t prod
);

    logic           valid_reg;
    qrm_pkg::prod_t prod_reg;
    qrm_pkg::prod_t prod_next;

    logic signed [31:0] w_i, w_j, w_k, w_r;

    always_comb
    begin
        w_i = 32'(quat.quat_i);
        w_j = 32'(quat.quat_j);
        w_k = 32'(quat.quat_k);
        w_r = 32'(quat.quat_r);
        prod_next.ii = 31'(w_i * w_i);
        prod_next.jj = 31'(w_j * w_j);
        prod_next.kk = 31'(w_k * w_k);
        prod_next.rr = 31'(w_r * w_r);
        prod_next.ij = w_i * w_j;
        prod_next.ik = w_i * w_k;
        prod_next.jk = w_j * w_k;
        prod_next.ir = w_i * w_r;
        prod_next.jr = w_j * w_r;
        prod_next.kr = w_k * w_r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod_valid = valid_reg;
    assign prod       = prod_reg;

endmodule

// ----- sv/qrm_numer.sv -----
module qrm_numer (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  en,
    input  logic                                                  prod_valid,
    input  qrm_pkg::prod_t                                        prod,
    output qrm_pkg::dctl_t                                        ctl,
    output logic [qrm_pkg::NUM_ENTRIES-1:0][qrm_pkg::REM_W-1:0]   mag
);

    logic            num_valid_reg;
    logic            ctl_valid_reg;
    qrm_pkg::numer_t numer_reg;
    qrm_pkg::numer_t numer_next;
    qrm_pkg::dctl_t  ctl_reg;
    qrm_pkg::dctl_t  ctl_next;
    logic [qrm_pkg::NUM_ENTRIES-1:0][qrm_pkg::REM_W-1:0] mag_reg;
    logic [qrm_pkg::NUM_ENTRIES-1:0][qrm_pkg::REM_W-1:0] mag_next;

    logic signed [34:0] s_ii, s_jj, s_kk, s_rr, s_ij, s_ik, s_jk, s_ir, s_jr, s_kr, s_n;
    logic signed [34:0] nv;
    logic signed [34:0] nabs;

    always_comb
    begin
        s_ii = $signed({4'b0, prod.ii});
        s_jj = $signed({4'b0, prod.jj});
        s_kk = $signed({4'b0, prod.kk});
        s_rr = $signed({4'b0, prod.rr});
        s_ij = $signed({{3{prod.ij[31]}}, prod.ij});
        s_ik = $signed({{3{prod.ik[31]}}, prod.ik});
        s_jk = $signed({{3{prod.jk[31]}}, prod.jk});
        s_ir = $signed({{3{prod.ir[31]}}, prod.ir});
        s_jr = $signed({{3{prod.jr[31]}}, prod.jr});
        s_kr = $signed({{3{prod.kr[31]}}, prod.kr});
        s_n  = s_ii + s_jj + s_kk + s_rr;
        numer_next.norm   = s_n[32:0];
        numer_next.num[0] = s_n - ((s_jj + s_kk) <<< 1);
        numer_next.num[1] = (s_ij - s_kr) <<< 1;
        numer_next.num[2] = (s_ik + s_jr) <<< 1;
        numer_next.num[3] = (s_ij + s_kr) <<< 1;
        numer_next.num[4] = s_n - ((s_ii + s_kk) <<< 1);
        numer_next.num[5] = (s_jk - s_ir) <<< 1;
        numer_next.num[6] = (s_ik - s_jr) <<< 1;
        numer_next.num[7] = (s_jk + s_ir) <<< 1;
        numer_next.num[8] = s_n - ((s_ii + s_jj) <<< 1);
    end

    always_comb
    begin
        nv   = '0;
        nabs = '0;
        ctl_next.valid = num_valid_reg;
        ctl_next.norm  = numer_reg.norm;
        ctl_next.zero  = (numer_reg.norm == '0);
        for (int e = 0; e < qrm_pkg::NUM_ENTRIES; e++)
        begin
            nv             = $signed(numer_reg.num[e]);
            nabs           = nv[34] ? -nv : nv;
            ctl_next.neg[e] = nv[34];
            mag_next[e]    = nabs[33:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_valid_reg <= 1'b0;
            ctl_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            num_valid_reg <= prod_valid;
            ctl_valid_reg <= ctl_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numer_reg <= numer_next;
            ctl_reg   <= ctl_next;
            mag_reg   <= mag_next;
        end
    end

    always_comb
    begin
        ctl       = ctl_reg;
        ctl.valid = ctl_valid_reg;
    end

    assign mag = mag_reg;

endmodule

// ----- sv/qrm_div_stage.sv -----
module qrm_div_stage #(
    parameter int QW = 16
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  en,
    input  qrm_pkg::dctl_t                                        ctl_in,
    input  logic [qrm_pkg::NUM_ENTRIES-1:0][qrm_pkg::REM_W-1:0]   rem_in,
    input  logic [qrm_pkg::NUM_ENTRIES-1:0][QW-1:0]               q_in,
    output qrm_pkg::dctl_t                                        ctl_out,
    output logic [qrm_pkg::NUM_ENTRIES-1:0][qrm_pkg::REM_W-1:0]   rem_out,
    output logic [qrm_pkg::NUM_ENTRIES-1:0][QW-1:0]               q_out
);

    logic           valid_reg;
    qrm_pkg::dctl_t ctl_reg;
    logic [qrm_pkg::NUM_ENTRIES-1:0][qrm_pkg::REM_W-1:0] rem_reg, rem_next;
    logic [qrm_pkg::NUM_ENTRIES-1:0][QW-1:0]             q_reg, q_next;

    logic [qrm_pkg::REM_W-1:0] dvs;
    logic [qrm_pkg::REM_W-1:0] diff;
    logic                      ge;

    always_comb
    begin
        dvs  = {1'b0, ctl_in.norm};
        diff = '0;
        ge   = 1'b0;
        for (int e = 0; e < qrm_pkg::NUM_ENTRIES; e++)
        begin
            ge          = (rem_in[e] >= dvs);
            diff        = ge ? (rem_in[e] - dvs) : rem_in[e];
            rem_next[e] = {diff[qrm_pkg::REM_W-2:0], 1'b0};
            q_next[e]   = {q_in[e][QW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg <= ctl_in;
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    always_comb
    begin
        ctl_out       = ctl_reg;
        ctl_out.valid = valid_reg;
    end

    assign rem_out = rem_reg;
    assign q_out   = q_reg;

endmodule

// ----- sv/qrm_round.sv -----
module qrm_round #(
    parameter int FRAC_BITS = 14,
    parameter int QW        = FRAC_BITS + 2
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  qrm_pkg::dctl_t                          ctl,
    input  logic [qrm_pkg::NUM_ENTRIES-1:0][QW-1:0] q,
    output logic                                    mat_valid,
    output qrm_pkg::mat_t                           mat
);

    localparam int OW = (QW + 1 > 16) ? QW + 1 : 16;
    localparam int NUM_ENTRIES_M1 = qrm_pkg::NUM_ENTRIES - 1;

    logic                 valid_reg;
    qrm_pkg::mat_t        mat_reg;
    qrm_pkg::mat_t        mat_next;
    logic [NUM_ENTRIES_M1:0][15:0] ent;

    logic [QW:0]   qr;
    logic [QW:0]   one_q;
    logic [OW-1:0] mag_w;
    logic [OW-1:0] res_w;
    logic [OW-1:0] one_w;

    always_comb
    begin
        one_q = (QW + 1)'(1) << FRAC_BITS;
        one_w = OW'(1) << FRAC_BITS;
        qr    = '0;
        mag_w = '0;
        res_w = '0;
        for (int e = 0; e < qrm_pkg::NUM_ENTRIES; e++)
        begin
            qr = ({1'b0, q[e]} + (QW + 1)'(1)) >> 1;
            if (qr > one_q)
            begin
                qr = one_q;
            end
            mag_w  = OW'(qr);
            res_w  = ctl.neg[e] ? (~mag_w + OW'(1)) : mag_w;
            ent[e] = res_w[15:0];
            if (ctl.zero)
            begin
                ent[e] = ((e % 4) == 0) ? one_w[15:0] : 16'd0;
            end
        end
        mat_next.m00       = ent[0];
        mat_next.m01       = ent[1];
        mat_next.m02       = ent[2];
        mat_next.m10       = ent[3];
        mat_next.m11       = ent[4];
        mat_next.m12       = ent[5];
        mat_next.m20       = ent[6];
        mat_next.m21       = ent[7];
        mat_next.m22       = ent[8];
        mat_next.zero_quat = ctl.zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mat_reg <= mat_next;
        end
    end

    assign mat_valid = valid_reg;
    assign mat       = mat_reg;

endmodule

// ----- sv/quaternion_to_rotation_matrix_top.sv -----
// Channel   Direction  Payload
// quat_in   sink       quat_i, quat_j, quat_k, quat_r (signed Q2.14)
// mat_out   source     m00..m22 (signed Q2.14), zero_quat
//
// One item enters per cycle while the output register is empty or being taken.
// Most of the pipeline is the long division, which resolves one quotient bit per stage.
// Reset clears only the valid bits of the stages.
// The whole pipeline advances whenever the output register is empty or being taken,
// so a stall holds every stage in place and loses nothing.
module quaternion_to_rotation_matrix_top #(
    parameter int FRAC_BITS = 14
) (
    input  logic         clk,
    input  logic         rst_n,
    qrm_quat_if.sink     quat_in,
    qrm_mat_if.source    mat_out
);

    localparam int QW = FRAC_BITS + 2;

    logic           en;
    logic           prod_valid;
    qrm_pkg::prod_t prod;
    logic           mat_valid;
    qrm_pkg::mat_t  mat;

    qrm_pkg::dctl_t ctl [0:QW];
    logic [qrm_pkg::NUM_ENTRIES-1:0][qrm_pkg::REM_W-1:0] rem [0:QW];
    logic [qrm_pkg::NUM_ENTRIES-1:0][QW-1:0]             qv  [0:QW];

    assign en            = !mat_valid || mat_out.ready;
    assign quat_in.ready = en;
    assign qv[0]         = '0;

    qrm_mul u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .valid      (quat_in.valid),
        .quat       (quat_in.data),
        .prod_valid (prod_valid),
        .prod       (prod)
    );

    qrm_numer u_numer (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .prod_valid (prod_valid),
        .prod       (prod),
        .ctl        (ctl[0]),
        .mag        (rem[0])
    );

    for (genvar s = 0; s < QW; s++)
    begin : g_div
        qrm_div_stage #(
            .QW (QW)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (ctl[s]),
            .rem_in  (rem[s]),
            .q_in    (qv[s]),
            .ctl_out (ctl[s+1]),
            .rem_out (rem[s+1]),
            .q_out   (qv[s+1])
        );
    end

    qrm_round #(
        .FRAC_BITS (FRAC_BITS),
        .QW        (QW)
    ) u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl       (ctl[QW]),
        .q         (qv[QW]),
        .mat_valid (mat_valid),
        .mat       (mat)
    );

    assign mat_out.valid = mat_valid;
    assign mat_out.data  = mat;

`ifndef SYNTH
    a_ready_follows_output : assert property (@(posedge clk) disable iff (!rst_n)
        quat_in.ready == (!mat_out.valid || mat_out.ready))
        else $error("input ready does not follow the output register");

    a_zero_off_diagonal : assert property (@(posedge clk) disable iff (!rst_n)
        (mat_out.valid && mat_out.data.zero_quat) |->
        (mat_out.data.m01 == 16'd0 && mat_out.data.m02 == 16'd0 &&
         mat_out.data.m10 == 16'd0 && mat_out.data.m12 == 16'd0 &&
         mat_out.data.m20 == 16'd0 && mat_out.data.m21 == 16'd0))
        else $error("zero quaternion gave a nonzero off-diagonal entry");

    a_zero_diagonal : assert property (@(posedge clk) disable iff (!rst_n)
        (mat_out.valid && mat_out.data.zero_quat) |->
        (mat_out.data.m00 == mat_out.data.m11 && mat_out.data.m11 == mat_out.data.m22))
        else $error("zero quaternion gave an uneven diagonal");
`endif

endmodule

// ----- tb/sv/tb_quaternion_to_rotation_matrix_top.sv -----
`timescale 1ns / 1ps

module tb_quaternion_to_rotation_matrix_top;

    localparam int FRAC = 14;
    localparam int LATENCY = FRAC + 6;
    localparam int N_RANDOM = 830;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    qrm_quat_if quat_in ();
    qrm_mat_if mat_out ();

    quaternion_to_rotation_matrix_top #(.FRAC_BITS(FRAC)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .quat_in(quat_in),
        .mat_out(mat_out)
    );

    qrm_pkg::quat_t pending_quats[$];
    qrm_pkg::mat_t expected_mats[$];
    int errors;
    int n_sent;
    int n_seen;
    int n_zero;
    longint cycles;
    bit stimulus_done;
    int send_gap;
    int take_gap;
    int hold_off;
    bit hold_done;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic signed [15:0] round_entry(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = ((mag <<< FRAC) * 2 + den) / (den * 2);
        if (q > (64'sd1 <<< FRAC))
            q = 64'sd1 <<< FRAC;
        if (num < 0)
            q = -q;
        return q[15:0];
    endfunction

    function automatic qrm_pkg::mat_t rotation_of(qrm_pkg::quat_t q);
        qrm_pkg::mat_t m;
        longint i, j, k, r, ii, jj, kk, nrm;
        i = q.quat_i;
        j = q.quat_j;
        k = q.quat_k;
        r = q.quat_r;
        ii = i * i;
        jj = j * j;
        kk = k * k;
        nrm = ii + jj + kk + r * r;
        m = '0;
        if (nrm == 0)
        begin
            m.m00 = 16'sd1 <<< FRAC;
            m.m11 = 16'sd1 <<< FRAC;
            m.m22 = 16'sd1 <<< FRAC;
            m.zero_quat = 1'b1;
            return m;
        end
        m.m00 = round_entry(nrm - 2 * (jj + kk), nrm);
        m.m01 = round_entry(2 * (i * j - k * r), nrm);
        m.m02 = round_entry(2 * (i * k + j * r), nrm);
        m.m10 = round_entry(2 * (i * j + k * r), nrm);
        m.m11 = round_entry(nrm - 2 * (ii + kk), nrm);
        m.m12 = round_entry(2 * (j * k - i * r), nrm);
        m.m20 = round_entry(2 * (i * k - j * r), nrm);
        m.m21 = round_entry(2 * (j * k + i * r), nrm);
        m.m22 = round_entry(nrm - 2 * (ii + jj), nrm);
        return m;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch on matrix %0d: %s got %0d expected %0d", n_seen, what, got, want);
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [15:0] rand_comp(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return $signed(16'($urandom_range(0, 16384))) - 16'sd8192;
            2: return $signed(16'($urandom_range(0, 15))) - 16'sd8;
            default: return 16'sd0;
        endcase
    endfunction

    task automatic queue_quat(int qi, int qj, int qk, int qr);
        qrm_pkg::quat_t q;
        q.quat_i = 16'(qi);
        q.quat_j = 16'(qj);
        q.quat_k = 16'(qk);
        q.quat_r = 16'(qr);
        pending_quats.push_back(q);
    endtask

    initial
    begin
        qrm_pkg::quat_t q;
        int mode;
        queue_quat(0, 0, 0, 0);
        queue_quat(0, 0, 0, 16384);
        queue_quat(16384, 0, 0, 0);
        queue_quat(0, 16384, 0, 0);
        queue_quat(0, 0, 16384, 0);
        queue_quat(0, 0, 0, -32768);
        queue_quat(-32768, -32768, -32768, -32768);
        queue_quat(32767, 32767, 32767, 32767);
        queue_quat(32767, -32768, 32767, -32768);
        queue_quat(-32768, 0, 0, 0);
        queue_quat(0, 0, 0, 1);
        queue_quat(1, 0, 0, 0);
        queue_quat(1, 1, 1, 1);
        queue_quat(-1, 1, -1, 1);
        queue_quat(11585, 0, 0, 11585);
        queue_quat(0, 11585, 0, -11585);
        queue_quat(1, 2, 3, 4);
        queue_quat(32767, 1, 0, 0);
        queue_quat(-21846, 16384, 5, -7);
        queue_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            mode = $urandom_range(0, 9);
            if (mode == 9)
                q = '0;
            else
            begin
                mode = (mode < 5) ? 0 : (mode < 8) ? 1 : 2;
                q.quat_i = rand_comp(($urandom_range(0, 5) == 0) ? 3 : mode);
                q.quat_j = rand_comp(($urandom_range(0, 5) == 0) ? 3 : mode);
                q.quat_k = rand_comp(($urandom_range(0, 5) == 0) ? 3 : mode);
                q.quat_r = rand_comp(($urandom_range(0, 5) == 0) ? 3 : mode);
            end
            pending_quats.push_back(q);
        end
        stimulus_done = 1'b1;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_in.valid <= 1'b0;
            quat_in.data <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (quat_in.valid && quat_in.ready)
            begin
                expected_mats.push_back(rotation_of(quat_in.data));
                n_sent <= n_sent + 1;
            end
            if (!quat_in.valid || quat_in.ready)
            begin
                if (send_gap > 0)
                begin
                    quat_in.valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_quats.size() > 0)
                begin
                    quat_in.valid <= 1'b1;
                    quat_in.data <= pending_quats.pop_front();
                    send_gap <= pick_gap();
                end
                else
                    quat_in.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off <= 0;
            hold_done <= 1'b0;
        end
        else if (n_sent == 200 && !hold_done)
        begin
            hold_off <= 3 * LATENCY;
            hold_done <= 1'b1;
        end
        else if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        qrm_pkg::mat_t want;
        qrm_pkg::mat_t got;
        if (!rst_n)
        begin
            mat_out.ready <= 1'b0;
            take_gap <= 0;
        end
        else
        begin
            if (mat_out.valid && mat_out.ready)
            begin
                got = mat_out.data;
                if (expected_mats.size() == 0)
                begin
                    errors++;
                    $display("unexpected matrix item after %0d", n_seen);
                end
                else
                begin
                    want = expected_mats.pop_front();
                    if (got.m00 !== want.m00) report_mismatch("m00", got.m00, want.m00);
                    if (got.m01 !== want.m01) report_mismatch("m01", got.m01, want.m01);
                    if (got.m02 !== want.m02) report_mismatch("m02", got.m02, want.m02);
                    if (got.m10 !== want.m10) report_mismatch("m10", got.m10, want.m10);
                    if (got.m11 !== want.m11) report_mismatch("m11", got.m11, want.m11);
                    if (got.m12 !== want.m12) report_mismatch("m12", got.m12, want.m12);
                    if (got.m20 !== want.m20) report_mismatch("m20", got.m20, want.m20);
                    if (got.m21 !== want.m21) report_mismatch("m21", got.m21, want.m21);
                    if (got.m22 !== want.m22) report_mismatch("m22", got.m22, want.m22);
                    if (got.zero_quat !== want.zero_quat)
                        report_mismatch("zero_quat", got.zero_quat, want.zero_quat);
                    if (want.zero_quat)
                        n_zero <= n_zero + 1;
                end
                n_seen <= n_seen + 1;
            end
            if (hold_off > 0)
                mat_out.ready <= 1'b0;
            else if (take_gap > 0)
            begin
                mat_out.ready <= 1'b0;
                take_gap <= take_gap - 1;
            end
            else
            begin
                mat_out.ready <= 1'b1;
                take_gap <= pick_gap();
            end
        end
    end

    initial
    begin
        errors = 0;
        n_sent = 0;
        n_seen = 0;
        n_zero = 0;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timed out after %0d cycles", cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        wait (stimulus_done);
        wait (pending_quats.size() == 0 && !quat_in.valid && expected_mats.size() == 0);
        repeat (2 * LATENCY) @(posedge clk);
        if (expected_mats.size() != 0)
        begin
            errors++;
            $display("%0d matrices never arrived", expected_mats.size());
        end
        $display("sent %0d quaternions and checked %0d matrices, %0d from zero input",
                 n_sent, n_seen, n_zero);
        $display("random idling on both sides with one long output stall, %0d errors", errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
